/* design/ble_pkg.sv */
// Shared types and constants for the bounded list engine.
// No dependencies; imported by ble_cmp, ble_ctrl and bounded_list_engine_top.
`default_nettype none

package ble_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int VAL_W     = 32;
    localparam int POS_OUT_W = 4;
    localparam int CNT_OUT_W = 5;
    localparam int OP_W      = 3;
    localparam int RES_W     = 16;

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_SORT = 3'd1,
        OP_SEARCH   = 3'd2,
        OP_REMOVE   = 3'd3,
        OP_CLEAR    = 3'd4
    } op_t;

    typedef struct packed {
        logic                 found;
        logic [POS_OUT_W-1:0] position;
        logic                 rejected;
        logic [CNT_OUT_W-1:0] count;
        logic                 empty_res;
    } res_t;

endpackage

`default_nettype wire

/* design/bounded_list_engine_top.sv */
// channel | dir | tdata (low bit first)                              | tuser
// s_      | in  | value[31:0]                                        | op[2:0]
// m_      | out | found, position[3:0], rejected, count[4:0], empty_res, zero fill | -
// One beat at a time: an item holds the sequencer until its result is passed on; the
// shortest items are clear, a spare code and a full insert, the longest a sorted insert
// into ENTRIES-1 entries. The table's single read port walks one entry a cycle in the
// scan and in the shift.
// Synchronous active-low reset empties the list; table contents are not cleared.
// A result waits in the output register; the next beat is taken once the sequencer idles.
// Depends on ble_pkg and ble_ctrl.
`default_nettype none

module bounded_list_engine_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [ble_pkg::VAL_W-1:0]   s_tdata,   // value[31:0]
    input  wire logic [ble_pkg::OP_W-1:0]    s_tuser,   // op[2:0]
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [ble_pkg::RES_W-1:0]        m_tdata    // found, position[3:0], rejected,
                                                        // count[4:0], empty_res, zeros
);
    import ble_pkg::*;

    logic             res_valid, res_ready;
    res_t             res;
    logic             m_valid_reg, m_valid_next;
    logic [RES_W-1:0] m_data_reg, m_data_next;

    ble_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (op_t'(s_tuser)),
        .in_value  ($signed(s_tdata)),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = {4'b0000, res.empty_res, res.count, res.rejected,
                            res.position, res.found};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

/* design/ble_cmp.sv */
// Shared compare unit: equality and signed less-than of a stored entry vs the operand.
// Depends on ble_pkg.
`default_nettype none

module ble_cmp (
    input  wire logic signed [ble_pkg::VAL_W-1:0] entry,
    input  wire logic signed [ble_pkg::VAL_W-1:0] operand,
    output logic                                  eq,
    output logic                                  lt
);
    import ble_pkg::*;

    assign eq = (entry == operand);
    assign lt = (entry < operand);

endmodule

`default_nettype wire

/* design/ble_ctrl.sv */
// Sequencer and entry table: walks the list one entry per cycle through the
// shared compare unit, then shifts entries up or down. Depends on ble_pkg, ble_cmp.
`default_nettype none

module ble_ctrl (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire ble_pkg::op_t                         in_op,
    input  wire logic signed [ble_pkg::VAL_W-1:0]     in_value,
    output logic                                      res_valid,
    input  wire logic                                 res_ready,
    output ble_pkg::res_t                             res
);
    import ble_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_SHIFT = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    op_t                       op_reg, op_next;
    logic signed [VAL_W-1:0]   value_reg, value_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [IDX_W-1:0]          pos_reg, pos_next;
    logic                      found_reg, found_next;
    logic                      rej_reg, rej_next;
    logic [CNT_W-1:0]          rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]          cmp_idx_reg, cmp_idx_next;
    logic                      dvld_reg, dvld_next;
    logic [IDX_W-1:0]          src_reg, src_next;
    logic [IDX_W-1:0]          wr_addr_reg, wr_addr_next;
    logic [CNT_W-1:0]          moves_reg, moves_next;
    logic                      up_reg, up_next;

    logic [VAL_W-1:0]          mem [ENTRIES];
    logic signed [VAL_W-1:0]   rd_data_reg;
    logic                      mem_we, mem_re;
    logic [IDX_W-1:0]          mem_waddr, mem_raddr;
    logic [VAL_W-1:0]          mem_wdata;

    logic                      cmp_eq, cmp_lt;
    logic                      full, hit, scan_end;
    logic [IDX_W-1:0]          hit_pos;

    ble_cmp u_cmp (
        .entry   (rd_data_reg),
        .operand (value_reg),
        .eq      (cmp_eq),
        .lt      (cmp_lt)
    );

    assign full     = (cnt_reg >= CNT_W'(ENTRIES));
    // sorted insert stops at the first entry not less than the operand
    assign hit      = dvld_reg && ((op_reg == OP_INS_SORT) ? !cmp_lt : cmp_eq);
    assign scan_end = hit || (rd_idx_reg >= cnt_reg);
    assign hit_pos  = hit ? cmp_idx_reg : IDX_W'(cnt_reg);

    assign in_ready      = (state_reg == ST_IDLE);
    assign res_valid     = (state_reg == ST_RESP);
    assign res.found     = found_reg;
    assign res.position  = POS_OUT_W'(pos_reg);
    assign res.rejected  = rej_reg;
    assign res.count     = CNT_OUT_W'(cnt_reg);
    assign res.empty_res = (cnt_reg == '0);

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        value_next   = value_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        found_next   = found_reg;
        rej_next     = rej_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_idx_next = cmp_idx_reg;
        dvld_next    = dvld_reg;
        src_next     = src_reg;
        wr_addr_next = wr_addr_reg;
        moves_next   = moves_reg;
        up_next      = up_reg;
        mem_we       = 1'b0;
        mem_waddr    = wr_addr_reg;
        mem_wdata    = rd_data_reg;
        mem_re       = 1'b0;
        mem_raddr    = src_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op_next     = in_op;
                    value_next  = in_value;
                    found_next  = 1'b0;
                    rej_next    = 1'b0;
                    pos_next    = '0;
                    rd_idx_next = '0;
                    dvld_next   = 1'b0;
                    case (in_op)
                        OP_INS_HEAD: begin
                            if (full) begin
                                rej_next   = 1'b1;
                                state_next = ST_RESP;
                            end else begin
                                found_next = 1'b1;
                                moves_next = cnt_reg;
                                src_next   = IDX_W'(cnt_reg - CNT_W'(1));
                                up_next    = 1'b0;
                                state_next = ST_SHIFT;
                            end
                        end
                        OP_INS_SORT: begin
                            if (full) begin
                                rej_next   = 1'b1;
                                state_next = ST_RESP;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_SEARCH, OP_REMOVE: begin
                            state_next = ST_SCAN;
                        end
                        OP_CLEAR: begin
                            cnt_next   = '0;
                            state_next = ST_RESP;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (scan_end) begin
                    dvld_next = 1'b0;
                    case (op_reg)
                        OP_INS_SORT: begin
                            found_next = 1'b1;
                            pos_next   = hit_pos;
                            moves_next = cnt_reg - CNT_W'(hit_pos);
                            src_next   = IDX_W'(cnt_reg - CNT_W'(1));
                            up_next    = 1'b0;
                            state_next = ST_SHIFT;
                        end
                        OP_REMOVE: begin
                            if (hit) begin
                                found_next = 1'b1;
                                pos_next   = cmp_idx_reg;
                                moves_next = cnt_reg - CNT_W'(cmp_idx_reg) - CNT_W'(1);
                                src_next   = cmp_idx_reg + IDX_W'(1);
                                up_next    = 1'b1;
                                state_next = ST_SHIFT;
                            end else begin
                                state_next = ST_RESP;
                            end
                        end
                        default: begin
                            if (hit) begin
                                found_next = 1'b1;
                                pos_next   = cmp_idx_reg;
                            end
                            state_next = ST_RESP;
                        end
                    endcase
                end else begin
                    // read the next entry while the previous one is compared
                    mem_re       = 1'b1;
                    mem_raddr    = rd_idx_reg[IDX_W-1:0];
                    cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    dvld_next    = 1'b1;
                end
            end

            ST_SHIFT: begin
                if (dvld_reg) begin
                    mem_we = 1'b1;
                end
                if (moves_reg != '0) begin
                    mem_re       = 1'b1;
                    mem_raddr    = src_reg;
                    wr_addr_next = up_reg ? src_reg - IDX_W'(1) : src_reg + IDX_W'(1);
                    src_next     = up_reg ? src_reg + IDX_W'(1) : src_reg - IDX_W'(1);
                    moves_next   = moves_reg - CNT_W'(1);
                    dvld_next    = 1'b1;
                end else begin
                    dvld_next = 1'b0;
                    if (op_reg == OP_REMOVE) begin
                        cnt_next   = cnt_reg - CNT_W'(1);
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_WRITE;
                    end
                end
            end

            ST_WRITE: begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = value_reg;
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = ST_RESP;
            end

            ST_RESP: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            dvld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dvld_reg  <= dvld_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        value_reg   <= value_next;
        pos_reg     <= pos_next;
        found_reg   <= found_next;
        rej_reg     <= rej_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        src_reg     <= src_next;
        wr_addr_reg <= wr_addr_next;
        moves_reg   <= moves_next;
        up_reg      <= up_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    a_found_not_rejected: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !(res.found && res.rejected))
        else $error("result both found and rejected");

    a_reject_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.rejected) |-> (cnt_reg == CNT_W'(ENTRIES)))
        else $error("insert rejected while list not full");

    a_write_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |=> (cnt_reg == ($past(cnt_reg) + CNT_W'(1))))
        else $error("insert did not grow the list");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |-> (moves_reg <= cnt_reg))
        else $error("shift length beyond list size");

endmodule

`default_nettype wire
